// File: sv/bwe_pkg.sv
// Shared types and constants of the bit-block transfer word engine.
// Used by the front, back and top level of the engine; depends on nothing.
package bwe_pkg;

  localparam logic [3:0] OpAnd  = 4'd1;
  localparam logic [3:0] OpCopy = 4'd3;
  localparam logic [3:0] OpOr   = 4'd7;

  localparam int unsigned FxsrBit = 7;
  localparam int unsigned NfsrBit = 6;

  typedef enum logic [2:0] {
    RegLogicOp    = 3'd0,
    RegFirstMask  = 3'd1,
    RegMiddleMask = 3'd2,
    RegLastMask   = 3'd3,
    RegSkewCtrl   = 3'd4,
    RegWordsLine  = 3'd5,
    RegLineCount  = 3'd6,
    RegReverse    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  logic_op;
    logic [15:0] first_mask;
    logic [15:0] middle_mask;
    logic [15:0] last_mask;
    logic [7:0]  skew_control;
    logic [15:0] words_per_line;
    logic [15:0] line_count;
    logic        reverse;
  } cfg_t;

  // Position flags that the front attaches to each request.
  typedef struct packed {
    logic first;
    logic line_last;
    logic final_line;
    logic clear_hold;
  } step_ctrl_t;

  typedef struct packed {
    logic [15:0] src_word;
    logic [15:0] prime_word;
    logic [15:0] dst_word;
    step_ctrl_t  ctrl;
  } step_t;

  typedef struct packed {
    logic [15:0] result_word;
    logic [1:0]  src_used;
    logic        line_end;
    logic        last;
  } result_t;

endpackage

// File: sv/bwe_fifo.sv
// Small first-in first-out queue of registered entries.
// Depends on nothing; the entry type is a parameter.
module bwe_fifo #(
  parameter int unsigned Depth = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count exceeds its depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill count did not grow on a lone push");

endmodule

// File: sv/bwe_front.sv
// Front of the word engine: tracks word and line position and tags each request.
// Depends on bwe_pkg for the configuration and request types.
module bwe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bwe_pkg::cfg_t       cfg_i,
  input  logic                acc_i,
  output bwe_pkg::step_ctrl_t ctrl_o
);

  logic [15:0] word_pos_q, word_pos_d;
  logic [15:0] line_pos_q, line_pos_d;
  logic [16:0] word_next, line_next;

  assign word_next = {1'b0, word_pos_q} + 17'd1;
  assign line_next = {1'b0, line_pos_q} + 17'd1;

  always_comb begin
    ctrl_o.first      = (word_pos_q == '0);
    ctrl_o.line_last  = (word_next >= {1'b0, cfg_i.words_per_line});
    ctrl_o.final_line = (line_next >= {1'b0, cfg_i.line_count});
    ctrl_o.clear_hold = (word_pos_q == '0) && (line_pos_q == '0);
  end

  // Positions at or past a shortened count still end the line or transfer.
  always_comb begin
    word_pos_d = word_pos_q;
    line_pos_d = line_pos_q;
    if (acc_i) begin
      if (ctrl_o.line_last) begin
        word_pos_d = '0;
        line_pos_d = ctrl_o.final_line ? '0 : line_next[15:0];
      end else begin
        word_pos_d = word_next[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_pos_q <= '0;
      line_pos_q <= '0;
    end else begin
      word_pos_q <= word_pos_d;
      line_pos_q <= line_pos_d;
    end
  end

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && ctrl_o.line_last |=> word_pos_q == '0)
    else $error("word position did not return to zero after a line end");

  a_xfer_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && ctrl_o.line_last && ctrl_o.final_line |=> ctrl_o.clear_hold)
    else $error("transfer end was not followed by a transfer start");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(word_pos_q) && $stable(line_pos_q))
    else $error("positions moved without an accepted request");

endmodule

// File: sv/bwe_back.sv
// Back of the word engine: hold register fill, skew shift and masked combine.
// Depends on bwe_pkg for the configuration, request and result types.
module bwe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bwe_pkg::cfg_t    cfg_i,
  input  bwe_pkg::step_t   step_i,
  input  logic             step_empty_i,
  output logic             step_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output bwe_pkg::result_t res_o
);

  logic [31:0] hold_q, hold_d;
  logic [31:0] h_clr, h_prime, h_fwd, h_fill, h_new;
  logic [15:0] mask, s_word, keep;
  logic        active, fxsr, nfsr, do_prime, do_read;
  logic [3:0]  skew;

  assign step_pop_o = !step_empty_i && !res_full_i;
  assign res_push_o = step_pop_o;

  assign fxsr     = cfg_i.skew_control[bwe_pkg::FxsrBit];
  assign nfsr     = cfg_i.skew_control[bwe_pkg::NfsrBit];
  assign skew     = cfg_i.skew_control[3:0];
  assign active   = (cfg_i.logic_op == bwe_pkg::OpAnd) ||
                    (cfg_i.logic_op == bwe_pkg::OpCopy) ||
                    (cfg_i.logic_op == bwe_pkg::OpOr);
  assign do_prime = step_i.ctrl.first && fxsr;
  assign do_read  = !(nfsr && step_i.ctrl.line_last);

  // Forward: swap halves, then refill the low half. Reverse: refill, then swap.
  always_comb begin
    h_clr   = step_i.ctrl.clear_hold ? 32'd0 : hold_q;
    h_prime = h_clr;
    if (do_prime) begin
      h_prime = cfg_i.reverse ? {step_i.prime_word, h_clr[15:0]}
                              : {h_clr[31:16], step_i.prime_word};
    end
    h_fwd  = cfg_i.reverse ? h_prime : {h_prime[15:0], h_prime[31:16]};
    h_fill = do_read ? {h_fwd[31:16], step_i.src_word} : h_fwd;
    h_new  = cfg_i.reverse ? {h_fill[15:0], h_fill[31:16]} : h_fill;
  end

  always_comb begin
    priority if (step_i.ctrl.first) begin
      mask = cfg_i.first_mask;
    end else if (step_i.ctrl.line_last) begin
      mask = cfg_i.last_mask;
    end else begin
      mask = cfg_i.middle_mask;
    end
  end

  assign s_word = h_new[15:0] >> skew | h_new[31:16] << (5'd16 - {1'b0, skew});
  assign keep   = step_i.dst_word & ~mask;

  always_comb begin
    res_o.line_end = step_i.ctrl.line_last;
    res_o.last     = step_i.ctrl.line_last && step_i.ctrl.final_line;
    res_o.src_used = 2'd0;
    res_o.result_word = step_i.dst_word;
    hold_d = hold_q;
    if (active) begin
      res_o.src_used = {1'b0, do_prime} + {1'b0, do_read};
      hold_d = h_new;
      if (cfg_i.logic_op == bwe_pkg::OpAnd) begin
        res_o.result_word = (step_i.dst_word & s_word & mask) | keep;
      end else if (cfg_i.logic_op == bwe_pkg::OpCopy) begin
        res_o.result_word = (s_word & mask) | keep;
      end else begin
        res_o.result_word = ((step_i.dst_word | s_word) & mask) | keep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (step_pop_o) begin
      hold_q <= hold_d;
    end
  end

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> res_o.src_used != 2'd3)
    else $error("more than two source words consumed by one request");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !active |-> res_o.src_used == 2'd0 &&
      res_o.result_word == step_i.dst_word)
    else $error("inactive opcode changed the destination or read source");

  a_hold_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_pop_o |=> $stable(hold_q))
    else $error("hold register changed without a request");

endmodule

// File: sv/bitblt_word_engine.sv
// Top level of the bit-block transfer word engine: configuration registers,
// front, request queue, back and result queue. Depends on bwe_pkg, bwe_fifo,
// bwe_front and bwe_back.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+----------------------------------------
//   input    | push / full                | src_word_i, prime_word_i, dst_word_i
//   result   | pop / empty                | result_word_o, src_used_o, line_end_o, last_o
//   config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while full stays low; a result passes through the request
// queue, then the result queue register, before it shows on the result ports.
// The back does the hold register update and the masked combine in the same cycle.
// Reset loads the register defaults and clears positions, hold and both queues.
// With pop held low the result queue fills, then the request queue, then full rises.
module bitblt_word_engine #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] src_word_i,
  input  logic [15:0] prime_word_i,
  input  logic [15:0] dst_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] result_word_o,
  output logic [1:0]  src_used_o,
  output logic        line_end_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  bwe_pkg::cfg_t       cfg_q, cfg_d;
  bwe_pkg::step_ctrl_t front_ctrl;
  bwe_pkg::step_t      front_step, back_step;
  bwe_pkg::result_t    back_res, out_res;
  logic                acc, step_empty, step_pop, res_full, res_push;
  logic [15:0]         wdata_sat;

  assign acc       = push && !full;
  assign wdata_sat = (cfg_wdata_i == '0) ? 16'd1 : cfg_wdata_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bwe_pkg::cfg_idx_e'(cfg_idx_i))
        bwe_pkg::RegLogicOp:    cfg_d.logic_op       = cfg_wdata_i[3:0];
        bwe_pkg::RegFirstMask:  cfg_d.first_mask     = cfg_wdata_i;
        bwe_pkg::RegMiddleMask: cfg_d.middle_mask    = cfg_wdata_i;
        bwe_pkg::RegLastMask:   cfg_d.last_mask      = cfg_wdata_i;
        bwe_pkg::RegSkewCtrl:   cfg_d.skew_control   = cfg_wdata_i[7:0];
        bwe_pkg::RegWordsLine:  cfg_d.words_per_line = wdata_sat;
        bwe_pkg::RegLineCount:  cfg_d.line_count     = wdata_sat;
        bwe_pkg::RegReverse:    cfg_d.reverse        = cfg_wdata_i[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.logic_op       <= bwe_pkg::OpCopy;
      cfg_q.first_mask     <= 16'hFFFF;
      cfg_q.middle_mask    <= 16'hFFFF;
      cfg_q.last_mask      <= 16'hFFFF;
      cfg_q.skew_control   <= '0;
      cfg_q.words_per_line <= 16'd1;
      cfg_q.line_count     <= 16'd1;
      cfg_q.reverse        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bwe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .acc_i  (acc),
    .ctrl_o (front_ctrl)
  );

  always_comb begin
    front_step.src_word   = src_word_i;
    front_step.prime_word = prime_word_i;
    front_step.dst_word   = dst_word_i;
    front_step.ctrl       = front_ctrl;
  end

  bwe_fifo #(
    .Depth  (QueueDepth),
    .item_t (bwe_pkg::step_t)
  ) u_step_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_step),
    .full_o  (full),
    .pop_i   (step_pop),
    .item_o  (back_step),
    .empty_o (step_empty)
  );

  bwe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .step_i       (back_step),
    .step_empty_i (step_empty),
    .step_pop_o   (step_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  bwe_fifo #(
    .Depth  (QueueDepth),
    .item_t (bwe_pkg::result_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .item_o  (out_res),
    .empty_o (empty)
  );

  assign result_word_o = out_res.result_word;
  assign src_used_o    = out_res.src_used;
  assign line_end_o    = out_res.line_end;
  assign last_o        = out_res.last;

endmodule

// File: test/tb_bitblt_word_engine.sv
// Self-checking testbench of bitblt_word_engine: directed and random destination steps,
// checked against an in-bench prediction of the skew, endmask and hold register behavior.
// Depends on bwe_pkg and the bitblt_word_engine RTL.
`timescale 1ns / 1ps

module tb_bitblt_word_engine;

  localparam int unsigned CycleLimit   = 800000;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned RandomItems  = 950;

  // Opcodes that leave the destination unchanged.
  localparam logic [3:0] OpKeepLow  = 4'd0;
  localparam logic [3:0] OpKeepHigh = 4'd15;

  localparam logic [7:0] FxsrFlag = 8'h01 << bwe_pkg::FxsrBit;
  localparam logic [7:0] NfsrFlag = 8'h01 << bwe_pkg::NfsrBit;

  class bwe_scoreboard;
    bwe_pkg::cfg_t    cfg;
    logic [31:0]      hold;
    logic [15:0]      word_pos;
    logic [15:0]      line_pos;
    bwe_pkg::result_t expected_q[$];
    int               errors;

    function new();
      cfg.logic_op       = bwe_pkg::OpCopy;
      cfg.first_mask     = 16'hFFFF;
      cfg.middle_mask    = 16'hFFFF;
      cfg.last_mask      = 16'hFFFF;
      cfg.skew_control   = 8'h00;
      cfg.words_per_line = 16'd1;
      cfg.line_count     = 16'd1;
      cfg.reverse        = 1'b0;
      hold     = '0;
      word_pos = '0;
      line_pos = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (bwe_pkg::cfg_idx_e'(idx))
        bwe_pkg::RegLogicOp:    cfg.logic_op = data[3:0];
        bwe_pkg::RegFirstMask:  cfg.first_mask = data;
        bwe_pkg::RegMiddleMask: cfg.middle_mask = data;
        bwe_pkg::RegLastMask:   cfg.last_mask = data;
        bwe_pkg::RegSkewCtrl:   cfg.skew_control = data[7:0];
        bwe_pkg::RegWordsLine:  cfg.words_per_line = (data == 16'd0) ? 16'd1 : data;
        bwe_pkg::RegLineCount:  cfg.line_count = (data == 16'd0) ? 16'd1 : data;
        bwe_pkg::RegReverse:    cfg.reverse = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [15:0] src, logic [15:0] prime, logic [15:0] dst);
      logic             first;
      logic             line_last;
      logic             final_line;
      logic             active;
      logic [1:0]       used;
      logic [15:0]      mask;
      logic [15:0]      operand;
      logic [15:0]      keep;
      logic [31:0]      shifted;
      bwe_pkg::result_t res;
      first      = (word_pos == 16'd0);
      line_last  = ({1'b0, word_pos} + 17'd1 >= {1'b0, cfg.words_per_line});
      final_line = ({1'b0, line_pos} + 17'd1 >= {1'b0, cfg.line_count});
      active     = (cfg.logic_op == bwe_pkg::OpAnd) || (cfg.logic_op == bwe_pkg::OpCopy) ||
                   (cfg.logic_op == bwe_pkg::OpOr);
      used       = 2'd0;
      res.result_word = dst;
      if (active) begin
        if (first && line_pos == 16'd0) hold = '0;
        if (first && cfg.skew_control[bwe_pkg::FxsrBit]) begin
          if (cfg.reverse) hold = {prime, hold[15:0]};
          else hold = {hold[31:16], prime};
          used = used + 2'd1;
        end
        if (!cfg.reverse) hold = {hold[15:0], hold[31:16]};
        if (!(cfg.skew_control[bwe_pkg::NfsrBit] && line_last)) begin
          hold = {hold[31:16], src};
          used = used + 2'd1;
        end
        if (cfg.reverse) hold = {hold[15:0], hold[31:16]};
        mask    = first ? cfg.first_mask : (line_last ? cfg.last_mask : cfg.middle_mask);
        shifted = hold >> cfg.skew_control[3:0];
        operand = shifted[15:0];
        keep    = dst & ~mask;
        if (cfg.logic_op == bwe_pkg::OpAnd) res.result_word = (dst & operand & mask) | keep;
        else if (cfg.logic_op == bwe_pkg::OpCopy) res.result_word = (operand & mask) | keep;
        else res.result_word = ((dst | operand) & mask) | keep;
      end
      if (line_last) begin
        word_pos = '0;
        line_pos = final_line ? 16'd0 : line_pos + 16'd1;
      end else begin
        word_pos = word_pos + 16'd1;
      end
      res.src_used = used;
      res.line_end = line_last;
      res.last     = line_last && final_line;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(bwe_pkg::result_t got);
      bwe_pkg::result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      compare_field("result_word", exp_res.result_word, got.result_word);
      compare_field("src_used", exp_res.src_used, got.src_used);
      compare_field("line_end", exp_res.line_end, got.line_end);
      compare_field("last", exp_res.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] src_word_i;
  logic [15:0] prime_word_i;
  logic [15:0] dst_word_i;
  logic        empty;
  logic        pop;
  logic [15:0] result_word_o;
  logic [1:0]  src_used_o;
  logic        line_end_o;
  logic        last_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  bwe_scoreboard sb;
  bit            rx_hold_req;
  bit            rx_holding;
  int unsigned   cycle_cnt;

  bitblt_word_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .src_word_i    (src_word_i),
    .prime_word_i  (prime_word_i),
    .dst_word_i    (dst_word_i),
    .empty         (empty),
    .pop           (pop),
    .result_word_o (result_word_o),
    .src_used_o    (src_used_o),
    .line_end_o    (line_end_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Pre-edge values are sampled here, so no result depends on event order.
  always @(posedge clk_i) begin
    bwe_pkg::result_t got;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (push && !full) sb.note_request(src_word_i, prime_word_i, dst_word_i);
      if (pop && !empty) begin
        got.result_word = result_word_o;
        got.src_used    = src_used_o;
        got.line_end    = line_end_o;
        got.last        = last_o;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random pop bursts and gaps, plus one long hold-off on request.
  initial begin
    int unsigned burst;
    int unsigned gap;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        pop <= 1'b0;
        rx_holding = 1'b1;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
        rx_holding  = 1'b0;
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 20);
        gap   = idle_len();
        pop <= 1'b1;
        repeat (burst) @(posedge clk_i);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  task automatic cfg_write(bwe_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the request until it is taken; push stays high unless a gap follows.
  task automatic send_step(logic [15:0] src, logic [15:0] prime, logic [15:0] dst,
                           int unsigned gap);
    push         <= 1'b1;
    src_word_i   <= src;
    prime_word_i <= prime;
    dst_word_i   <= dst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic randomize_config();
    int unsigned r;
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 9);
      if (r < 3) cfg_write(bwe_pkg::RegLogicOp, 16'(bwe_pkg::OpAnd));
      else if (r < 6) cfg_write(bwe_pkg::RegLogicOp, 16'(bwe_pkg::OpCopy));
      else if (r < 9) cfg_write(bwe_pkg::RegLogicOp, 16'(bwe_pkg::OpOr));
      else cfg_write(bwe_pkg::RegLogicOp, 16'($urandom_range(0, 15)));
    end
    if ($urandom_range(0, 9) < 7) cfg_write(bwe_pkg::RegFirstMask, rand_word());
    if ($urandom_range(0, 9) < 7) cfg_write(bwe_pkg::RegMiddleMask, rand_word());
    if ($urandom_range(0, 9) < 7) cfg_write(bwe_pkg::RegLastMask, rand_word());
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 9);
      if (r == 0) cfg_write(bwe_pkg::RegSkewCtrl, 16'h0000);
      else if (r == 1) cfg_write(bwe_pkg::RegSkewCtrl, 16'h00FF);
      else cfg_write(bwe_pkg::RegSkewCtrl, 16'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      if (r == 0) cfg_write(bwe_pkg::RegWordsLine, 16'd0);
      else if (r == 1) cfg_write(bwe_pkg::RegWordsLine, 16'hFFFF);
      else if (r < 5) cfg_write(bwe_pkg::RegWordsLine, 16'($urandom_range(9, 40)));
      else cfg_write(bwe_pkg::RegWordsLine, 16'($urandom_range(1, 8)));
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      if (r == 0) cfg_write(bwe_pkg::RegLineCount, 16'd0);
      else if (r == 1) cfg_write(bwe_pkg::RegLineCount, 16'hFFFF);
      else cfg_write(bwe_pkg::RegLineCount, 16'($urandom_range(1, 4)));
    end
    if ($urandom_range(0, 9) < 5) cfg_write(bwe_pkg::RegReverse, 16'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned items_sent;
    int unsigned phase;
    int unsigned burst_len;
    bit          hold_phase;
    sb = new();
    rx_hold_req = 1'b0;
    rx_holding  = 1'b0;
    cycle_cnt   = 0;
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    src_word_i   <= '0;
    prime_word_i <= '0;
    dst_word_i   <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= bwe_pkg::RegLogicOp;
    cfg_wdata_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: one-word copy transfers.
    send_step(16'hFFFF, 16'h0000, 16'h0000, 0);
    send_step(16'h0000, 16'hFFFF, 16'hFFFF, 1);
    wait_drained();

    // AND with an extra first read and distinct endmasks over two three-word lines.
    cfg_write(bwe_pkg::RegLogicOp, 16'(bwe_pkg::OpAnd));
    cfg_write(bwe_pkg::RegFirstMask, 16'h0FFF);
    cfg_write(bwe_pkg::RegMiddleMask, 16'hFFFF);
    cfg_write(bwe_pkg::RegLastMask, 16'hF000);
    cfg_write(bwe_pkg::RegSkewCtrl, 16'(FxsrFlag | 8'd5));
    cfg_write(bwe_pkg::RegWordsLine, 16'd3);
    cfg_write(bwe_pkg::RegLineCount, 16'd2);
    send_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_step(16'h0000, 16'hFFFF, 16'hFFFF, 0);
    send_step(16'hA5A5, 16'h0000, 16'hFFFF, 2);
    send_step(16'h1234, 16'h8001, 16'hFFFF, 0);
    send_step(16'hFFFF, 16'h0000, 16'h0000, 0);
    send_step(16'h8000, 16'hFFFF, 16'hFFFF, 0);
    wait_drained();

    // OR in reverse with full skew and no final read.
    cfg_write(bwe_pkg::RegLogicOp, 16'(bwe_pkg::OpOr));
    cfg_write(bwe_pkg::RegReverse, 16'd1);
    cfg_write(bwe_pkg::RegSkewCtrl, 16'(NfsrFlag | 8'd15));
    cfg_write(bwe_pkg::RegFirstMask, 16'hFFFF);
    cfg_write(bwe_pkg::RegMiddleMask, 16'h5A5A);
    cfg_write(bwe_pkg::RegLastMask, 16'h0000);
    send_step(16'hFFFF, 16'h0000, 16'h0000, 0);
    send_step(16'h0001, 16'h0000, 16'h0000, 0);
    send_step(16'hFFFF, 16'hFFFF, 16'h0000, 0);
    send_step(16'h8000, 16'h0000, 16'h0000, 3);
    send_step(16'h0000, 16'h0000, 16'hFFFF, 0);
    send_step(16'hFFFF, 16'h0000, 16'h0000, 0);
    wait_drained();

    // Opcodes that keep the destination; positions still advance.
    cfg_write(bwe_pkg::RegLogicOp, 16'(OpKeepLow));
    send_step(16'hFFFF, 16'hFFFF, 16'h1357, 0);
    send_step(16'hFFFF, 16'hFFFF, 16'h0000, 0);
    wait_drained();
    cfg_write(bwe_pkg::RegLogicOp, 16'(OpKeepHigh));
    send_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    wait_drained();

    // Zero counts saturate to one-word lines, with both extra reads set.
    cfg_write(bwe_pkg::RegLogicOp, 16'(bwe_pkg::OpCopy));
    cfg_write(bwe_pkg::RegReverse, 16'd0);
    cfg_write(bwe_pkg::RegWordsLine, 16'd0);
    cfg_write(bwe_pkg::RegLineCount, 16'd0);
    cfg_write(bwe_pkg::RegSkewCtrl, 16'(FxsrFlag | NfsrFlag | 8'd3));
    send_step(16'hFFFF, 16'hF0F0, 16'h0000, 0);
    send_step(16'h0000, 16'hFFFF, 16'h0000, 0);
    send_step(16'hFFFF, 16'h0000, 16'hFFFF, 0);
    wait_drained();

    // Shrink the line length while a line is under way.
    cfg_write(bwe_pkg::RegSkewCtrl, 16'd4);
    cfg_write(bwe_pkg::RegWordsLine, 16'd5);
    cfg_write(bwe_pkg::RegLineCount, 16'd3);
    send_step(16'h1111, 16'h0000, 16'h0000, 0);
    send_step(16'h2222, 16'h0000, 16'h0000, 0);
    send_step(16'h3333, 16'h0000, 16'h0000, 0);
    wait_drained();
    cfg_write(bwe_pkg::RegWordsLine, 16'd2);
    cfg_write(bwe_pkg::RegLineCount, 16'd1);
    send_step(16'h4444, 16'h0000, 16'hFFFF, 0);
    send_step(16'h5555, 16'h0000, 16'hFFFF, 0);
    wait_drained();

    items_sent = 0;
    phase = 0;
    while (items_sent < RandomItems) begin
      randomize_config();
      hold_phase = (phase == 3);
      burst_len = hold_phase ? 150 : $urandom_range(15, 70);
      // The receiver stalls while requests keep coming, so full has to rise.
      if (hold_phase) begin
        rx_hold_req = 1'b1;
        wait (rx_holding);
      end
      repeat (burst_len) begin
        send_step(rand_word(), rand_word(), rand_word(), hold_phase ? 0 : idle_len());
        items_sent++;
      end
      wait_drained();
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bwe_pkg.sv
sv/bwe_fifo.sv
sv/bwe_front.sv
sv/bwe_back.sv
sv/bitblt_word_engine.sv
test/tb_bitblt_word_engine.sv
